[rtl/stack_machine_execute_unit_defines.svh]
// Assertion macros for the stack machine execute unit.
// No dependencies; included by the top level.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMEU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SMEU_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SMEU_ASSERT(label, clk, rst_n, prop)
`define SMEU_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/smeu_pkg.sv]
// Package for the stack machine execute unit: sizes, opcodes and status codes.
// No dependencies.
package smeu_pkg;
  localparam int StackDepth   = 4096;
  localparam int RegCount     = 16;
  localparam int ProgramDepth = 4096;
  localparam int SpW  = $clog2(StackDepth + 1);
  localparam int SaW  = $clog2(StackDepth);
  localparam int PcW  = $clog2(ProgramDepth);
  localparam int RiW  = (RegCount > 1) ? $clog2(RegCount) : 1;

  typedef enum logic [3:0] {
    OpPush = 4'd0, OpPop = 4'd1, OpPushi = 4'd2, OpJmp = 4'd3, OpCmp = 4'd4,
    OpJiez = 4'd5, OpJigz = 4'd6, OpJilz = 4'd7, OpJgez = 4'd8, OpJlez = 4'd9,
    OpAdd = 4'd10, OpSub = 4'd11, OpMul = 4'd12, OpDiv = 4'd13, OpRem = 4'd14,
    OpHalt = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StHalt = 3'd1, StOvf = 3'd2, StUnf = 3'd3, StDivZero = 3'd4,
    StPcRange = 3'd5, StIgnored = 3'd6
  } status_e;
endpackage

[rtl/stack_machine_execute_unit.sv]
// Top level of the stack machine execute unit: sequencer, register file, stack RAM,
// shared 64-bit multiply / divide unit. Uses smeu_pkg, smeu_ram and the defines header.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one instruction per transfer:
//    mode_i, reg_index_i, immediate_i. Output channel (out_valid_o / out_stall_i)
//    returns one result per instruction: status, next pc, written value, stack depth,
//    branch flag.
//  - Items are handled one at a time. Mul sums three 32x32 partial products
//    (low and two cross terms) in the shared unit; div/rem form one quotient bit
//    per cycle there. A new instruction can be taken as soon as the result is
//    valid, unless the output is stalled.
//  - The result sits in an output register; while it is stalled, no new instruction
//    is taken, so the output fields stay put until the transfer.
//  - Reset clears registers, pointers, pc and stop flag; program_length resets to 4096.
//    The stack RAM is not cleared: only entries below the pointer are ever read.
//  - Halt or any fault stops the unit; later instructions return "ignored" until reset.
//  - cfg_we_i writes program_length; write only while idle.
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mode_i,
  input  logic [3:0]  reg_index_i,
  input  logic signed [63:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [11:0] next_pc_o,
  output logic signed [63:0] written_value_o,
  output logic [12:0] stack_depth_o,
  output logic        branch_taken_o
);
`include "stack_machine_execute_unit_defines.svh"

  typedef enum logic [3:0] {
    SIdle, SRdA, SRdB, SGetA, SGetB, SMul, SDiv, SFinish, SResult
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic [RiW-1:0] ri_q;
  logic           ri_ok_q;
  logic [63:0]    imm_q;
  logic [SpW-1:0] sp_q;
  logic [PcW-1:0] pc_q;
  logic           stopped_q;
  logic [12:0]    plen_q;
  logic [63:0]    rf_q [RegCount];
  logic [63:0]    a_q, b_q, acc_q, rem_q, quo_q;
  logic [6:0]     cnt_q;
  logic [63:0]    res_q;

  // result register
  logic           ovalid_q;
  logic [2:0]     ost_q;
  logic [PcW-1:0] opc_q;
  logic [63:0]    owv_q;
  logic [SpW-1:0] osp_q;
  logic           obr_q;

  // stack RAM
  logic           ram_we;
  logic [SaW-1:0] ram_waddr, ram_raddr;
  logic [63:0]    ram_wdata, ram_rdata;

  smeu_ram #(.Width(64), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // effective pc limit
  logic [13:0] lim;
  assign lim = (32'(plen_q) < ProgramDepth) ? 14'(plen_q) : 14'(ProgramDepth);

  logic accept;
  assign in_stall_o = (state_q != SIdle) || (ovalid_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  // shared unit: 32x32 partial product and one restoring-divide step
  logic [63:0] ua, ub;
  assign ua = a_q[63] ? -a_q : a_q;
  assign ub = b_q[63] ? -b_q : b_q;
  logic [1:0]  pp_sel;
  assign pp_sel = cnt_q[1:0];
  logic [31:0] pa, pb;
  assign pa = pp_sel[0] ? a_q[63:32] : a_q[31:0];
  assign pb = pp_sel[1] ? b_q[63:32] : b_q[31:0];
  logic [63:0] pprod;
  assign pprod = pa * pb;
  logic [64:0] rshift, rtrial;
  assign rshift = {rem_q, quo_q[63]};
  assign rtrial = rshift - {1'b0, ub};

  // jump condition on the popped value
  logic cond;
  always_comb begin
    unique case (op_q)
      OpJiez:  cond = (a_q == '0);
      OpJigz:  cond = !a_q[63] && (a_q != '0);
      OpJilz:  cond = a_q[63];
      OpJgez:  cond = !a_q[63];
      default: cond = a_q[63] || (a_q == '0);
    endcase
  end

  assign ram_raddr = (state_q == SRdA) ? SaW'(sp_q - 1'b1) : SaW'(sp_q - 2'd2);

  // pc + 1 / target check at finish
  logic        jumped;
  logic [63:0] target;
  always_comb begin
    jumped = ((op_q == OpJmp) ||
              ((op_q >= OpJiez) && (op_q <= OpJlez) && cond));
    target = jumped ? imm_q : 64'(pc_q) + 64'd1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SaW'(sp_q);
    ram_wdata = res_q;
    if (state_q == SFinish) begin
      if (op_q == OpPush || op_q == OpPushi) begin
        ram_we = 1'b1;
      end else if (op_q == OpCmp || (op_q >= OpAdd && op_q <= OpRem)) begin
        ram_we    = 1'b1;
        ram_waddr = SaW'(sp_q - 2'd2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      sp_q      <= '0;
      pc_q      <= '0;
      stopped_q <= 1'b0;
      plen_q    <= 13'd4096;
      ovalid_q  <= 1'b0;
      for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
    end else begin
      if (cfg_we_i) plen_q <= cfg_wdata_i;
      // SResult reloads the register itself when the old result leaves
      if (ovalid_q && !out_stall_i && (state_q != SResult)) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            op_q    <= op_e'(mode_i);
            ri_q    <= RiW'(reg_index_i);
            ri_ok_q <= (32'(reg_index_i) < RegCount);
            imm_q   <= immediate_i;
            res_q   <= (mode_i == OpPushi) ? immediate_i :
                       (32'(reg_index_i) < RegCount) ? rf_q[RiW'(reg_index_i)] : '0;
            if (stopped_q) begin
              ost_q <= StIgnored; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
            end else if (14'(pc_q) >= lim) begin
              stopped_q <= 1'b1;
              ost_q <= StPcRange; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
            end else begin
              priority case (1'b1)
                (mode_i == OpHalt): begin
                  stopped_q <= 1'b1;
                  ost_q <= StHalt; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
                end
                (mode_i == OpPush || mode_i == OpPushi): begin
                  if (32'(sp_q) >= StackDepth) begin
                    stopped_q <= 1'b1;
                    ost_q <= StOvf; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
                  end else state_q <= SFinish;
                end
                (mode_i == OpJmp): state_q <= SFinish;
                (mode_i == OpPop || (mode_i >= OpJiez && mode_i <= OpJlez)): begin
                  if (sp_q == '0) begin
                    stopped_q <= 1'b1;
                    ost_q <= StUnf; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
                  end else state_q <= SRdA;
                end
                default: begin
                  if (sp_q < SpW'(2)) begin
                    stopped_q <= 1'b1;
                    ost_q <= StUnf; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
                  end else state_q <= SRdA;
                end
              endcase
            end
          end
        end
        SRdA: begin
          // read address for a presented; b follows for binary ops
          state_q <= (op_q == OpPop || (op_q >= OpJiez && op_q <= OpJlez)) ? SGetA : SRdB;
        end
        SRdB: begin
          a_q     <= ram_rdata;
          state_q <= SGetB;
        end
        SGetA: begin
          a_q   <= ram_rdata;
          res_q <= ram_rdata;
          sp_q  <= sp_q - 1'b1;
          if (op_q == OpPop && ri_ok_q) rf_q[ri_q] <= ram_rdata;
          state_q <= SFinish;
        end
        SGetB: begin
          b_q <= ram_rdata;
          cnt_q <= '0;
          acc_q <= '0;
          if ((op_q == OpDiv || op_q == OpRem) && ram_rdata == '0) begin
            stopped_q <= 1'b1;
            ost_q <= StDivZero; owv_q <= '0; obr_q <= 1'b0; state_q <= SResult;
          end else if (op_q == OpMul) begin
            state_q <= SMul;
          end else if (op_q == OpDiv || op_q == OpRem) begin
            state_q <= SDiv;
          end else begin
            res_q <= (op_q == OpAdd) ? a_q + ram_rdata : a_q - ram_rdata;
            state_q <= SFinish;
          end
        end
        SMul: begin
          // low product, two cross terms, high term dropped
          cnt_q <= cnt_q + 1'b1;
          unique case (pp_sel)
            2'd0: acc_q <= pprod;
            2'd1, 2'd2: acc_q <= acc_q + {pprod[31:0], 32'd0};
            default: begin
              res_q   <= acc_q;
              state_q <= SFinish;
            end
          endcase
        end
        SDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'd0) begin
            rem_q <= '0;
            quo_q <= ua;
          end else if (cnt_q <= 7'd64) begin
            if (!rtrial[64]) begin
              rem_q <= rtrial[63:0];
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rshift[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
          end else begin
            if (op_q == OpDiv) res_q <= (a_q[63] ^ b_q[63]) ? -quo_q : quo_q;
            else               res_q <= a_q[63] ? -rem_q : rem_q;
            state_q <= SFinish;
          end
        end
        SFinish: begin
          if (op_q == OpPush || op_q == OpPushi) sp_q <= sp_q + 1'b1;
          else if (op_q == OpCmp || (op_q >= OpAdd && op_q <= OpRem)) sp_q <= sp_q - 1'b1;
          owv_q <= (op_q == OpJmp || (op_q >= OpJiez && op_q <= OpJlez)) ? '0 : res_q;
          if (target >= 64'(lim)) begin
            stopped_q <= 1'b1;
            ost_q <= StPcRange; obr_q <= 1'b0;
          end else begin
            pc_q  <= PcW'(target);
            ost_q <= StOk; obr_q <= jumped;
          end
          state_q <= SResult;
        end
        default: begin // SResult: wait for the output register to be free
          if (!ovalid_q || !out_stall_i) begin
            ovalid_q <= 1'b1;
            opc_q    <= pc_q;
            osp_q    <= sp_q;
            state_q  <= SIdle;
          end
        end
      endcase
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = ost_q;
  assign next_pc_o       = 12'(opc_q);
  assign written_value_o = owv_q;
  assign stack_depth_o   = 13'(osp_q);
  assign branch_taken_o  = obr_q;

  `SMEU_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != SIdle) |-> in_stall_o)
  `SMEU_ASSERT(a_hold_out, clk_i, rst_ni,
               (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(owv_q)))
  `SMEU_ASSERT(a_sp_range, clk_i, rst_ni, (32'(sp_q) <= StackDepth))
  `SMEU_ASSERT(a_stop_sticky, clk_i, rst_ni, stopped_q |=> stopped_q)
endmodule

[rtl/smeu_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module smeu_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[bench/tb_stack_machine_execute_unit.sv]
// Self-checking bench for stack_machine_execute_unit: directed and random programs,
// random idling on both channels. Depends on smeu_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  typedef struct {
    logic [3:0]  mode;
    logic [3:0]  reg_idx;
    logic [63:0] imm;
  } instr_t;

  typedef struct {
    status_e     status;
    logic [11:0] pc;
    logic [63:0] wval;
    logic [12:0] depth;
    logic        taken;
  } outcome_t;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned IdleLimit = 3000;

  // Machine shadow: executes each accepted instruction and queues the result it should give.
  class exec_scoreboard;
    logic [63:0] regs [RegCount];
    logic [63:0] stk [StackDepth];
    int unsigned sp, pc, plen;
    bit stopped;
    outcome_t pending[$];
    int errors, checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      sp = 0; pc = 0; plen = 4096; stopped = 0; errors = 0; checked = 0;
    endfunction

    function int unsigned limit();
      return (plen < ProgramDepth) ? plen : ProgramDepth;
    endfunction

    // Signed divide / remainder, truncating toward zero; min / -1 wraps.
    function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b, bit want_rem);
      logic [63:0] ua, ub, q, r;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (want_rem) return a[63] ? -r : r;
      return (a[63] ^ b[63]) ? -q : q;
    endfunction

    // Outcome of one instruction; state changes only when commit is set.
    function outcome_t run(instr_t it, bit commit);
      outcome_t o;
      logic [63:0] tgt, wv, v, a, b, res;
      int unsigned nsp, lim;
      bit jumped, cond;
      lim = limit();
      tgt = 64'(pc) + 64'd1;
      wv = '0;
      jumped = 0;
      nsp = sp;
      o.pc = pc[11:0]; o.wval = '0; o.depth = sp[12:0]; o.taken = 0; o.status = StOk;
      if (stopped) begin
        o.status = StIgnored;
        return o;
      end
      if (pc >= lim) begin
        if (commit) stopped = 1;
        o.status = StPcRange;
        return o;
      end
      case (op_e'(it.mode))
        OpPush, OpPushi: begin
          if (sp >= StackDepth) begin
            if (commit) stopped = 1;
            o.status = StOvf;
            return o;
          end
          v = (op_e'(it.mode) == OpPushi) ? it.imm : regs[it.reg_idx];
          if (commit) stk[sp] = v;
          nsp = sp + 1;
          wv = v;
        end
        OpPop: begin
          if (sp == 0) begin
            if (commit) stopped = 1;
            o.status = StUnf;
            return o;
          end
          v = stk[sp-1];
          if (commit) regs[it.reg_idx] = v;
          nsp = sp - 1;
          wv = v;
        end
        OpJmp: begin
          tgt = it.imm;
          jumped = 1;
        end
        OpJiez, OpJigz, OpJilz, OpJgez, OpJlez: begin
          if (sp == 0) begin
            if (commit) stopped = 1;
            o.status = StUnf;
            return o;
          end
          v = stk[sp-1];
          nsp = sp - 1;
          case (op_e'(it.mode))
            OpJiez: cond = (v == 0);
            OpJigz: cond = !v[63] && (v != 0);
            OpJilz: cond = v[63];
            OpJgez: cond = !v[63];
            default: cond = v[63] || (v == 0);
          endcase
          if (cond) begin
            tgt = it.imm;
            jumped = 1;
          end
        end
        OpHalt: begin
          if (commit) stopped = 1;
          o.status = StHalt;
          return o;
        end
        default: begin
          if (sp < 2) begin
            if (commit) stopped = 1;
            o.status = StUnf;
            return o;
          end
          a = stk[sp-1];
          b = stk[sp-2];
          if ((op_e'(it.mode) == OpDiv || op_e'(it.mode) == OpRem) && b == 0) begin
            if (commit) stopped = 1;
            o.status = StDivZero;
            return o;
          end
          case (op_e'(it.mode))
            OpAdd:   res = a + b;
            OpMul:   res = a * b;
            OpDiv:   res = sdiv(a, b, 0);
            OpRem:   res = sdiv(a, b, 1);
            default: res = a - b;   // sub and cmp
          endcase
          if (commit) stk[sp-2] = res;
          nsp = sp - 1;
          wv = res;
        end
      endcase
      o.wval = wv;
      o.depth = nsp[12:0];
      if (commit) sp = nsp;
      if (tgt >= lim) begin
        // next pc out of range: stack and register effects stay, pc does not move
        if (commit) stopped = 1;
        o.status = StPcRange;
        return o;
      end
      if (commit) pc = tgt;
      o.pc = tgt[11:0];
      o.taken = jumped;
      return o;
    endfunction

    function void note_input(instr_t it);
      pending.push_back(run(it, 1));
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.pc !== exp.pc) begin
        $error("next_pc: expected %0d, got %0d", exp.pc, got.pc);
        errors++;
      end
      if (got.wval !== exp.wval) begin
        $error("written_value: expected %h, got %h", exp.wval, got.wval);
        errors++;
      end
      if (got.depth !== exp.depth) begin
        $error("stack_depth: expected %0d, got %0d", exp.depth, got.depth);
        errors++;
      end
      if (got.taken !== exp.taken) begin
        $error("branch_taken: expected %0d, got %0d", exp.taken, got.taken);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] mode_i = '0;
  logic [3:0] reg_index_i = '0;
  logic signed [63:0] immediate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [11:0] next_pc_o;
  logic signed [63:0] written_value_o;
  logic [12:0] stack_depth_o;
  logic branch_taken_o;

  exec_scoreboard sb = new();
  bit calm = 0;               // no idling on either side while set
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_in = 0;
  int unsigned n_cfg = 0;

  always #6 clk_i = ~clk_i;

  stack_machine_execute_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .reg_index_i    (reg_index_i),
    .immediate_i    (immediate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .next_pc_o      (next_pc_o),
    .written_value_o(written_value_o),
    .stack_depth_o  (stack_depth_o),
    .branch_taken_o (branch_taken_o)
  );

  // Result side: check each transfer, draw the next stall, and watch for a hang.
  always @(posedge clk_i) begin
    outcome_t got;
    if (out_valid_o && !out_stall_i) begin
      got.status = status_e'(status_o);
      got.pc = next_pc_o;
      got.wval = written_value_o;
      got.depth = stack_depth_o;
      got.taken = branch_taken_o;
      sb.check_result(got);
      stall_left = calm ? 0 : $urandom_range(0, 13);
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // One input transfer: optional gap, then hold the instruction until taken.
  task automatic send(instr_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = it.mode;
    reg_index_i = it.reg_idx;
    immediate_i = it.imm;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    n_in++;
    @(negedge clk_i);
  endtask

  task automatic op(op_e m, logic [3:0] ri, logic [63:0] imm);
    instr_t it;
    it.mode = m;
    it.reg_idx = ri;
    it.imm = imm;
    send(it);
  endtask

  // Block goes idle once everything outstanding has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_plen(logic [12:0] val);
    op(OpJmp, 4'd0, 64'd0);   // park pc at 0 so any limit stays legal
    drain();
    cfg_wdata_i = val;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.plen = val;
    n_cfg++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return MinVal;
      1: return MaxVal;
      2: return 64'(int'($urandom_range(0, 40)) - 20);
      3: return -64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int unsigned w;
    it.reg_idx = 4'($urandom_range(0, 15));
    it.imm = pick_value();
    w = $urandom_range(0, 99);
    if (w < 22) it.mode = OpPushi;
    else if (w < 32) it.mode = OpPush;
    else if (w < 42) it.mode = OpPop;
    else if (w < 58) begin
      case ($urandom_range(0, 5))
        0: it.mode = OpCmp;
        1: it.mode = OpAdd;
        2: it.mode = OpSub;
        3: it.mode = OpMul;
        4: it.mode = OpDiv;
        default: it.mode = OpRem;
      endcase
    end else if (w < 75) it.mode = 4'(int'(OpJiez) + $urandom_range(0, 4));
    else if (w < 82) it.mode = OpJmp;
    else if (w < 85) it.mode = 4'($urandom_range(0, 15));   // raw noise, usually filtered
    else it.mode = OpPushi;
    // jump targets mostly land inside the program
    if ((it.mode == OpJmp || (it.mode >= OpJiez && it.mode <= OpJlez)) &&
        $urandom_range(0, 7) != 0)
      it.imm = 64'($urandom_range(0, sb.limit() - 1));
    return it;
  endfunction

  // Random instructions that keep the machine running; anything that would stop it
  // is redrawn, with a jump to 0 as the always-legal fallback.
  task automatic random_phase(int unsigned count);
    instr_t it;
    bit ok;
    repeat (count) begin
      ok = 0;
      for (int t = 0; t < 30 && !ok; t++) begin
        it = rand_instr();
        ok = (sb.run(it, 0).status == StOk);
      end
      if (!ok) begin
        it.mode = OpJmp;
        it.reg_idx = 4'($urandom_range(0, 15));
        it.imm = 64'd0;
      end
      send(it);
    end
  endtask

  initial begin
    logic [12:0] plens [5];
    int unsigned pick;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every opcode but halt, min / -1 for div and rem
    op(OpPushi, 4'd0, MaxVal);
    op(OpPushi, 4'd0, MinVal);
    op(OpAdd, 4'd0, 64'd0);         // -1
    op(OpPop, 4'd15, 64'd0);
    op(OpPush, 4'd15, 64'd0);
    op(OpPushi, 4'd0, MinVal);
    op(OpDiv, 4'd0, 64'd0);         // min / -1 wraps
    op(OpPushi, 4'd0, -64'd1);
    op(OpPushi, 4'd0, MinVal);
    op(OpRem, 4'd0, 64'd0);         // min % -1 is zero
    op(OpMul, 4'd0, 64'd0);
    op(OpPushi, 4'd0, 64'd7);
    op(OpSub, 4'd0, 64'd0);
    op(OpPushi, 4'd0, 64'd3);
    op(OpCmp, 4'd0, 64'd0);         // -4
    op(OpJilz, 4'd0, 64'd20);
    op(OpPushi, 4'd0, 64'd0);
    op(OpJiez, 4'd0, 64'd30);
    op(OpPushi, 4'd0, 64'd5);
    op(OpJigz, 4'd0, 64'd2);
    op(OpPushi, 4'd0, -64'd3);
    op(OpJgez, 4'd0, 64'd9);        // not taken
    op(OpPushi, 4'd0, 64'd0);
    op(OpJlez, 4'd0, 64'd40);
    op(OpJmp, 4'd0, 64'd4095);      // last legal pc
    op(OpJmp, 4'd0, 64'd0);
    drain();

    // phases under different program lengths, extremes included
    plens[0] = 13'h1FFF;
    plens[1] = 13'd1;
    plens[2] = 13'($urandom_range(2, 4095));
    plens[3] = 13'd2;
    plens[4] = 13'd4096;
    random_phase(60);
    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      write_plen(plens[p]);
      random_phase(95);
    end
    calm = 0;
    drain();

    // one terminal event, then a few instructions that must be ignored
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      op(OpHalt, 4'd0, 64'd0);
    end else if (pick == 1) begin
      op(OpPushi, 4'd0, 64'd0);
      op(OpPushi, 4'd0, 64'd9);
      op(OpDiv, 4'd0, 64'd0);
    end else begin
      op(OpJmp, 4'd0, -64'd1);
    end
    op(OpHalt, 4'd3, 64'd0);
    op(OpPushi, 4'd0, MaxVal);
    op(OpPop, 4'd1, 64'd0);
    in_valid_i = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    $display("Ran %0d instructions, %0d results checked, %0d program-length writes.",
             n_in, sb.checked, n_cfg);
    $display("Terminal event variant %0d, then ignored instructions after stop.", pick);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
